// ===== hw/rtl/mpfg_pkg.sv =====
package mpfg_pkg;

    // one generator word and a group of four lanes (index 0 is lane a)
    typedef logic [31:0]       t_word;
    typedef logic [3:0][31:0]  t_quad;

    // operation codes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    // generator modes
    localparam logic MODE_XORSHIFT = 1'b0;
    localparam logic MODE_GALOIS   = 1'b1;

    // configuration register indexes
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_TAPS = 1'b1;

    localparam t_word TAPS_RESET    = 32'h8001_7BAE;
    localparam t_word FLOAT_EXP_ONE = 32'h3F80_0000;
    localparam int    MAX_GROUPS    = 16;

    typedef struct packed {
        logic        operation;
        logic [3:0]  group_index;
        logic [31:0] seed_a;
        logic [31:0] seed_b;
        logic [31:0] seed_c;
        logic [31:0] seed_d;
    } t_item;

    typedef struct packed {
        logic [3:0]  out_group;
        logic [31:0] raw_a;
        logic [31:0] raw_b;
        logic [31:0] raw_c;
        logic [31:0] raw_d;
        logic [31:0] float_a;
        logic [31:0] float_b;
        logic [31:0] float_c;
        logic [31:0] float_d;
        logic        last_group;
    } t_result;

    // xorshift32 with shifts 13, 17, 5
    function automatic t_word next_xorshift(input t_word x);
        t_word a;
        t_word b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    // galois lfsr, right shifting
    function automatic t_word next_galois(input t_word x, input t_word taps);
        return x[0] ? ((x >> 1) ^ taps) : (x >> 1);
    endfunction

    // sign from bit 0, exponent 127, mantissa from bits 31..9
    function automatic t_word to_float(input t_word w);
        return (w >> 9) | FLOAT_EXP_ONE | {w[0], 31'd0};
    endfunction

endpackage

// ===== hw/rtl/mpfg_update.sv =====
module mpfg_update (
    input  logic           i_mode,
    input  mpfg_pkg::t_word i_taps,
    input  mpfg_pkg::t_quad i_quad,
    output mpfg_pkg::t_quad o_quad
);

    // advance the four lanes leaving the head of the ring
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (i_mode == mpfg_pkg::MODE_GALOIS) begin
                o_quad[k] = mpfg_pkg::next_galois(i_quad[k], i_taps);
            end else begin
                o_quad[k] = mpfg_pkg::next_xorshift(i_quad[k]);
            end
        end
    end

endmodule

// ===== hw/rtl/mpfg_cell.sv =====
module mpfg_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  mpfg_pkg::t_quad i_shift_data,
    input  logic            i_load,
    input  logic [3:0]      i_load_mask,
    input  mpfg_pkg::t_quad i_load_data,
    output mpfg_pkg::t_quad o_data
);

    mpfg_pkg::t_quad r_data;
    mpfg_pkg::t_quad n_data;

    // take the neighbor's group while rotating, else seed masked lanes
    always_comb begin
        n_data = r_data;
        if (i_shift) begin
            n_data = i_shift_data;
        end else if (i_load) begin
            for (int k = 0; k < 4; k++) begin
                if (i_load_mask[k]) begin
                    n_data[k] = i_load_data[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/multi_lane_prng_float_gen_core.sv =====
// Multi-lane random word generator with float conversion.
// Input channel: i_item is taken at a rising edge with i_start high and o_busy
// low. A load item writes four seeds into one lane group in that cycle and
// gives no result; o_busy stays low, so another item may follow at once.
// A generate item rotates the ring of group cells once around: each cycle the
// head group passes the update unit, is registered as a result and re-enters at
// the tail. The length of a run is set by the length of the cell ring; o_busy
// is high for the whole run.
// Result channel: o_strobe marks o_result for one cycle; the first group comes
// after the start has passed through r_busy and the result register, then one
// group per cycle, at most sixteen, last_group on the final one. The receiver
// cannot stall; results are never held back.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 mode,
// 1 taps) at the edge; only while idle, a rule the block does not enforce.
// Reset (synchronous, active low) clears all lanes to zero, the mode to
// xorshift, the taps to their default and ends any run.
module multi_lane_prng_float_gen_core #(
    parameter int LANE_COUNT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  mpfg_pkg::t_item   i_item,
    output logic              o_strobe,
    output mpfg_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);

    localparam int NC      = (LANE_COUNT + 3) / 4;
    localparam int NG_FULL = LANE_COUNT / 4;
    localparam int NG_OUT  = (NG_FULL > mpfg_pkg::MAX_GROUPS) ? mpfg_pkg::MAX_GROUPS : NG_FULL;
    localparam int CNT_W   = (NC > 1) ? $clog2(NC) : 1;

    logic                  r_mode;
    mpfg_pkg::t_word       r_taps;
    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_strobe;
    mpfg_pkg::t_result     r_result;

    logic                  w_accept;
    logic                  w_load;
    mpfg_pkg::t_quad       w_seeds;
    mpfg_pkg::t_quad       w_next_head;
    mpfg_pkg::t_quad       w_cell_q [NC];
    logic                  w_at_end;

    assign w_accept = i_start && !r_busy;
    assign w_load   = w_accept && (i_item.operation == mpfg_pkg::OP_LOAD);
    assign w_seeds  = {i_item.seed_d, i_item.seed_c, i_item.seed_b, i_item.seed_a};
    assign w_at_end = (int'(r_cnt) == NC - 1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mpfg_pkg::MODE_XORSHIFT;
            r_taps <= mpfg_pkg::TAPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mpfg_pkg::CFG_MODE: r_mode <= i_cfg_data[0];
                mpfg_pkg::CFG_TAPS: r_taps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // run control: one ring rotation per generate item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (w_at_end) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (w_accept && (i_item.operation == mpfg_pkg::OP_GENERATE)) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end
    end

    // update unit at the head of the ring
    mpfg_update u_update (
        .i_mode (r_mode),
        .i_taps (r_taps),
        .i_quad (w_cell_q[0]),
        .o_quad (w_next_head)
    );

    // ring of group cells, the updated head group re-enters at the tail
    for (genvar i = 0; i < NC; i++) begin : g_cell
        logic [3:0]      w_mask;
        mpfg_pkg::t_quad w_in;

        for (genvar k = 0; k < 4; k++) begin : g_mask
            assign w_mask[k] = (i * 4 + k < LANE_COUNT);
        end

        if (i == NC - 1) begin : g_tail
            assign w_in = w_next_head;
        end else begin : g_mid
            assign w_in = w_cell_q[i + 1];
        end

        mpfg_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (r_busy),
            .i_shift_data (w_in),
            .i_load       (w_load && (int'(i_item.group_index) == i)),
            .i_load_mask  (w_mask),
            .i_load_data  (w_seeds),
            .o_data       (w_cell_q[i])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_busy && (int'(r_cnt) < NG_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.out_group  <= 4'(r_cnt);
        r_result.raw_a      <= w_next_head[0];
        r_result.raw_b      <= w_next_head[1];
        r_result.raw_c      <= w_next_head[2];
        r_result.raw_d      <= w_next_head[3];
        r_result.float_a    <= mpfg_pkg::to_float(w_next_head[0]);
        r_result.float_b    <= mpfg_pkg::to_float(w_next_head[1]);
        r_result.float_c    <= mpfg_pkg::to_float(w_next_head[2]);
        r_result.float_d    <= mpfg_pkg::to_float(w_next_head[3]);
        r_result.last_group <= (int'(r_cnt) == NG_OUT - 1);
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/mpfg_checker.sv =====
module mpfg_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input mpfg_pkg::t_item   i_item,
    input logic              o_strobe,
    input mpfg_pkg::t_result o_result
);

    // results only come out of a run
    a_strobe_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(o_busy))
        else $error("result outside a generate run");

    // a generate item starts a run, a load item does not
    a_gen_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_item.operation == mpfg_pkg::OP_GENERATE)) |=> o_busy)
        else $error("generate item did not start a run");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_item.operation == mpfg_pkg::OP_LOAD)) |=> !o_busy)
        else $error("load item made the block busy");

    // groups of a run come back to back in ascending order
    a_group_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_group) |=>
            (o_strobe && (o_result.out_group == 4'($past(o_result.out_group) + 4'd1))))
        else $error("result groups out of order");

    // the final group is followed by a gap
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_group) |=> !o_strobe)
        else $error("result right after the final group");

endmodule

bind multi_lane_prng_float_gen_core mpfg_checker u_mpfg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== verif/tb_multi_lane_prng_float_gen_core.sv =====
module tb_multi_lane_prng_float_gen_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mpfg_pkg::*;

    localparam int LANES      = 64;
    localparam int IDLE_LIMIT = 1000;
    localparam int RAND_ITEMS = 420;

    // predicted lane bank and the queue of groups still to come out
    class lane_bank_scoreboard;
        t_word   lanes [LANES];
        logic    mode;
        t_word   taps;
        t_result groups_due [$];
        int      errors;
        int      checked;
        int      loads;
        int      generates;
        int      reg_writes;

        function new();
            foreach (lanes[l]) lanes[l] = '0;
            mode       = MODE_XORSHIFT;
            taps       = TAPS_RESET;
            errors     = 0;
            checked    = 0;
            loads      = 0;
            generates  = 0;
            reg_writes = 0;
        endfunction

        function int pending();
            return groups_due.size();
        endfunction

        function void set_reg(logic idx, t_word data);
            reg_writes++;
            if (idx == CFG_MODE) begin
                mode = data[0];
            end else begin
                taps = data;
            end
        endfunction

        // xorshift32, shifts 13 / 17 / 5
        function t_word xs_next(t_word x);
            t_word v;
            v = x;
            v = v ^ {v[18:0], 13'd0};
            v = v ^ {17'd0, v[31:17]};
            v = v ^ {v[26:0], 5'd0};
            return v;
        endfunction

        // right-shifting galois lfsr with the current tap mask
        function t_word lfsr_next(t_word x);
            t_word v;
            v = {1'b0, x[31:1]};
            if (x[0]) v = v ^ taps;
            return v;
        endfunction

        // sign from bit 0, biased exponent 127, mantissa from the top 23 bits
        function t_word float_bits(t_word w);
            return {w[0], 8'h7F, w[31:9]};
        endfunction

        function void note_item(t_item it);
            t_word   seeds [4];
            t_result grp;
            int      n_groups;
            int      lane;
            seeds[0] = it.seed_a;
            seeds[1] = it.seed_b;
            seeds[2] = it.seed_c;
            seeds[3] = it.seed_d;
            if (it.operation == OP_LOAD) begin
                loads++;
                for (int k = 0; k < 4; k++) begin
                    lane = int'(it.group_index) * 4 + k;
                    if (lane < LANES) lanes[lane] = seeds[k];
                end
                return;
            end
            generates++;
            for (int l = 0; l < LANES; l++) begin
                lanes[l] = (mode == MODE_GALOIS) ? lfsr_next(lanes[l]) : xs_next(lanes[l]);
            end
            n_groups = LANES / 4;
            if (n_groups > MAX_GROUPS) n_groups = MAX_GROUPS;
            for (int g = 0; g < n_groups; g++) begin
                grp.out_group  = g[3:0];
                grp.raw_a      = lanes[4 * g];
                grp.raw_b      = lanes[4 * g + 1];
                grp.raw_c      = lanes[4 * g + 2];
                grp.raw_d      = lanes[4 * g + 3];
                grp.float_a    = float_bits(lanes[4 * g]);
                grp.float_b    = float_bits(lanes[4 * g + 1]);
                grp.float_c    = float_bits(lanes[4 * g + 2]);
                grp.float_d    = float_bits(lanes[4 * g + 3]);
                grp.last_group = (g == n_groups - 1);
                groups_due.push_back(grp);
            end
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_group(t_result got);
            t_result want;
            if (groups_due.size() == 0) begin
                $display("%0t: unexpected group, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = groups_due.pop_front();
            checked++;
            compare("out_group", 32'(want.out_group), 32'(got.out_group));
            compare("raw_a", want.raw_a, got.raw_a);
            compare("raw_b", want.raw_b, got.raw_b);
            compare("raw_c", want.raw_c, got.raw_c);
            compare("raw_d", want.raw_d, got.raw_d);
            compare("float_a", want.float_a, got.float_a);
            compare("float_b", want.float_b, got.float_b);
            compare("float_c", want.float_c, got.float_c);
            compare("float_d", want.float_d, got.float_d);
            compare("last_group", 32'(want.last_group), 32'(got.last_group));
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_start    = 1'b0;
    t_item       i_item     = '0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_strobe;
    t_result     o_result;

    lane_bank_scoreboard sb;
    int                  idle_cycles = 0;

    multi_lane_prng_float_gen_core #(
        .LANE_COUNT (LANES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_group(o_result);
        end
    end

    // watchdog on cycles with neither an accepted item nor a result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_strobe) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired with %0d groups outstanding",
                         $time, sb.pending());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic t_item make_item(logic op, logic [3:0] grp, t_word a, t_word b,
                                        t_word c, t_word d);
        t_item it;
        it.operation   = op;
        it.group_index = grp;
        it.seed_a      = a;
        it.seed_b      = b;
        it.seed_c      = c;
        it.seed_d      = d;
        return it;
    endfunction

    // seeds lean toward zero, all ones and single bits
    function automatic t_word rand_seed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 14) return '1;
        if (r < 20) return t_word'(1) << $urandom_range(0, 31);
        return $urandom;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(21, 60);
    endfunction

    // hold one item on the port until it is taken, then leave the port idle for the gap
    task automatic send_item(t_item it, int gap);
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(it);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every predicted group has come out
    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, t_word data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic md, t_word tp);
        drain();
        write_reg(CFG_MODE, {t_word'($urandom) & 32'hFFFF_FFFE} | t_word'(md));
        write_reg(CFG_TAPS, tp);
    endtask

    initial begin
        int    rand_count;
        int    phase;
        int    gen_pct;
        bit    quiet;
        logic  md;
        t_word tp;
        logic  op;

        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all-zero bank after reset, then extreme seeds
        send_item(make_item(OP_GENERATE, 4'd0, '0, '0, '0, '0), 0);
        send_item(make_item(OP_LOAD, 4'd0, '1, 32'h1, 32'h8000_0000, '0), 0);
        send_item(make_item(OP_LOAD, 4'd15, '0, '1, 32'h0000_FFFF, 32'hFFFF_0000), 2);
        send_item(make_item(OP_LOAD, 4'd7, $urandom, $urandom, $urandom, $urandom), 0);
        send_item(make_item(OP_GENERATE, 4'd0, '0, '0, '0, '0), 0);
        // fields other than the operation are ignored on a generate
        send_item(make_item(OP_GENERATE, 4'd15, '1, '1, '1, '1), 0);
        send_item(make_item(OP_LOAD, 4'd0, 32'h1234_5678, '0, '1, 32'h5555_AAAA), 1);

        // galois with the default taps, mode data with upper bits set
        drain();
        write_reg(CFG_MODE, '1);
        write_reg(CFG_TAPS, TAPS_RESET);
        send_item(make_item(OP_GENERATE, 4'd3, '0, '0, '0, '0), 0);
        send_item(make_item(OP_GENERATE, 4'd0, '0, '0, '0, '0), 3);

        // galois with no taps and with every tap
        drain();
        write_reg(CFG_TAPS, '0);
        send_item(make_item(OP_GENERATE, 4'd0, '0, '0, '0, '0), 0);
        drain();
        write_reg(CFG_TAPS, '1);
        send_item(make_item(OP_GENERATE, 4'd0, '0, '0, '0, '0), 0);
        send_item(make_item(OP_LOAD, 4'd3, 32'h1, 32'h2, 32'h3, '1), 0);
        send_item(make_item(OP_GENERATE, 4'd0, '0, '0, '0, '0), 0);

        // back to xorshift, upper bits of the mode data set
        drain();
        write_reg(CFG_MODE, 32'hFFFF_FFFE);
        send_item(make_item(OP_GENERATE, 4'd0, '0, '0, '0, '0), 0);

        // random phases, each under its own register setting
        rand_count = 0;
        phase      = 0;
        while (rand_count < RAND_ITEMS) begin
            case (phase)
                0: begin md = MODE_XORSHIFT; tp = TAPS_RESET;     end
                1: begin md = MODE_GALOIS;   tp = TAPS_RESET;     end
                2: begin md = MODE_GALOIS;   tp = '0;             end
                3: begin md = MODE_GALOIS;   tp = '1;             end
                4: begin md = MODE_XORSHIFT; tp = $urandom;       end
                5: begin md = MODE_GALOIS;   tp = 32'h8000_0000;  end
                default: begin
                    md = 1'($urandom_range(0, 1));
                    tp = $urandom;
                end
            endcase
            apply_setting(md, tp);
            quiet   = ($urandom_range(0, 3) == 0);
            gen_pct = $urandom_range(25, 70);

            // on a coin toss, fresh seeds into every group so the lanes are not left at zero
            if ($urandom_range(0, 1) == 1) begin
                for (int g = 0; g < 16; g++) begin
                    send_item(make_item(OP_LOAD, g[3:0], rand_seed(), rand_seed(),
                                        rand_seed(), rand_seed()),
                              quiet ? 0 : rand_gap());
                    rand_count++;
                end
            end

            for (int n = 0; n < 40; n++) begin
                op = ($urandom_range(0, 99) < gen_pct) ? OP_GENERATE : OP_LOAD;
                send_item(make_item(op, 4'($urandom_range(0, 15)), rand_seed(),
                                    rand_seed(), rand_seed(), rand_seed()),
                          quiet ? 0 : rand_gap());
                rand_count++;
                // now and then the sender holds off until the block has emptied
                if ($urandom_range(0, 29) == 0) drain();
            end
            phase++;
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d groups never came out", $time, sb.pending());
            sb.errors++;
        end
        $display("run covered %0d loads and %0d generates over %0d setting phases",
                 sb.loads, sb.generates, phase);
        $display("%0d groups compared, %0d register writes, %0d mismatches",
                 sb.checked, sb.reg_writes, sb.errors);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mpfg_pkg.sv
hw/rtl/mpfg_update.sv
hw/rtl/mpfg_cell.sv
hw/rtl/multi_lane_prng_float_gen_core.sv
hw/rtl/mpfg_checker.sv
verif/tb_multi_lane_prng_float_gen_core.sv
